/* sv/fsl_pkg.sv */
// ----------------------------------------------------------------------------
// fsl_pkg
// Shared types and constants of the fixed-string line filter.
// ----------------------------------------------------------------------------
package fsl_pkg;

  localparam int unsigned POS_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 64;
  localparam int unsigned PLEN_W    = 5;
  localparam int unsigned PAT_BYTES = 16;

  localparam logic [7:0] NEWLINE_BYTE = 8'd10;

  localparam longint unsigned STREAM_MAX = 64'd65536;
  localparam logic [POS_W-1:0] POS_LIMIT =
    ((STREAM_MAX - 64'd1) < 64'd65535) ? POS_W'(STREAM_MAX - 64'd1) : {POS_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LO  = 2'd0,
    REG_PAT_HI  = 2'd1,
    REG_PAT_LEN = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_EOD  = 1'b1
  } item_kind_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic [POS_W-1:0] line_offset;
    logic [POS_W-1:0] line_length;
    logic             final_line;
  } result_t;

endpackage

/* sv/fsl_ifs.sv */
// ----------------------------------------------------------------------------
// fsl_ifs
// Valid/ready channel interfaces: text input, line result, register write.
// ----------------------------------------------------------------------------
interface fsl_in_if import fsl_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] text_byte;

  modport source (output valid, output kind, output text_byte, input ready);
  modport sink   (input valid, input kind, input text_byte, output ready);
endinterface

interface fsl_out_if import fsl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] line_offset;
  logic [POS_W-1:0] line_length;
  logic             final_line;

  modport source (output valid, output line_offset, output line_length, output final_line,
                  input ready);
  modport sink   (input valid, input line_offset, input line_length, input final_line,
                  output ready);
endinterface

interface fsl_cfg_if import fsl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/fsl_cell.sv */
// ----------------------------------------------------------------------------
// fsl_cell
// One window cell: holds one recent byte of the line, passes it on to the
// next cell and compares the byte it takes in against its pattern byte.
// ----------------------------------------------------------------------------
module fsl_cell import fsl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  logic [7:0] prev_byte,
  input  logic       prev_valid,
  input  logic [7:0] pat_byte,
  input  logic       pat_en,
  output logic [7:0] byte_r,
  output logic       valid_r,
  output logic       match
);

  assign match = !pat_en || (prev_valid && (prev_byte == pat_byte));

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      byte_r <= prev_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      valid_r <= 1'b0;
    end else if (ctrl.shift) begin
      valid_r <= prev_valid;
    end
  end

endmodule

/* sv/fixed_string_line_filter_core.sv */
// ----------------------------------------------------------------------------
// fixed_string_line_filter_core
// Reports the lines of a byte stream that contain a fixed pattern.
//
// in_ch  : one beat per text byte (kind 0) or end of data (kind 1).
// out_ch : one beat per matching line: start offset, length without the
//          newline, and whether end of data closed it.
// cfg_ch : register writes (pattern low word, high word, length), always
//          ready; write only while no line result is outstanding.
// Throughput is one input beat per cycle while in_ch is ready. A row of
// PATTERN_MAX window cells shifts each byte in and compares every position
// against the pattern in the same cycle. The closing beat of a matching
// line pushes its result into a two-entry queue that drives out_ch from
// registers; in_ch stays ready while one result waits and drops ready only
// when both entries are held by a stalled receiver. Reset clears pattern
// registers, window, offsets and queue; end of data zeroes the offsets.
// ----------------------------------------------------------------------------
module fixed_string_line_filter_core import fsl_pkg::*; #(
  parameter int unsigned PATTERN_MAX = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  fsl_in_if.sink       in_ch,
  fsl_out_if.source    out_ch,
  fsl_cfg_if.sink      cfg_ch
);

  logic [CFG_DAT_W-1:0] pat_lo_r;
  logic [CFG_DAT_W-1:0] pat_hi_r;
  logic [PLEN_W-1:0]    pat_len_r;
  logic [PLEN_W-1:0]    plen;
  logic [8*PAT_BYTES-1:0] pat_word;

  logic [POS_W-1:0] pos_r, pos_nxt, pos_inc;
  logic [POS_W-1:0] start_r, start_nxt;
  logic             hit_r, hit_nxt;
  logic             accept, is_data, hit_now, push, pop;
  cell_ctrl_t       ctrl;
  result_t          res;

  logic [7:0]             cell_byte  [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] cell_valid;
  logic [PATTERN_MAX-1:0] cell_match;

  result_t    q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;

  // configuration
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r  <= '0;
      pat_hi_r  <= '0;
      pat_len_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_PAT_LO:  pat_lo_r  <= cfg_ch.data;
        REG_PAT_HI:  pat_hi_r  <= cfg_ch.data;
        REG_PAT_LEN: pat_len_r <= cfg_ch.data[PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign plen     = (pat_len_r > PATTERN_MAX) ? PLEN_W'(PATTERN_MAX) : pat_len_r;
  assign pat_word = {pat_hi_r, pat_lo_r};

  // window row
  assign accept  = in_ch.valid && in_ch.ready;
  assign is_data = (item_kind_t'(in_ch.kind) == KIND_DATA) && (in_ch.text_byte != NEWLINE_BYTE);

  assign ctrl.shift = accept && is_data;
  assign ctrl.clear = accept && !is_data;

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic [7:0]        prev_byte;
    logic              prev_valid;
    logic [7:0]        pat_byte;
    logic              pat_en;
    logic [PLEN_W-1:0] pidx;

    if (k == 0) begin : g_head
      assign prev_byte  = in_ch.text_byte;
      assign prev_valid = 1'b1;
    end else begin : g_link
      assign prev_byte  = cell_byte[k-1];
      assign prev_valid = cell_valid[k-1];
    end

    if (k < (1 << PLEN_W)) begin : g_used
      assign pat_en = plen > PLEN_W'(k);
      assign pidx   = plen - PLEN_W'(1) - PLEN_W'(k);
    end else begin : g_unused
      assign pat_en = 1'b0;
      assign pidx   = '0;
    end

    assign pat_byte = pidx[PLEN_W-1] ? 8'h00 : pat_word[{pidx[3:0], 3'b000} +: 8];

    fsl_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .prev_byte  (prev_byte),
      .prev_valid (prev_valid),
      .pat_byte   (pat_byte),
      .pat_en     (pat_en),
      .byte_r     (cell_byte[k]),
      .valid_r    (cell_valid[k]),
      .match      (cell_match[k])
    );
  end

  assign hit_now = (plen != '0) && (&cell_match);

  // line tracking
  assign pos_inc = (pos_r < POS_LIMIT) ? pos_r + POS_W'(1) : pos_r;

  always_comb begin
    pos_nxt   = pos_r;
    start_nxt = start_r;
    hit_nxt   = hit_r;
    push      = 1'b0;
    res.line_offset = start_r;
    res.line_length = pos_r - start_r;
    res.final_line  = in_ch.kind;
    if (accept) begin
      if (is_data) begin
        pos_nxt = pos_inc;
        hit_nxt = hit_r || hit_now;
      end else begin
        push    = hit_r || (plen == '0);
        hit_nxt = 1'b0;
        if (item_kind_t'(in_ch.kind) == KIND_EOD) begin
          pos_nxt   = '0;
          start_nxt = '0;
        end else begin
          pos_nxt   = pos_inc;
          start_nxt = pos_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      start_r <= '0;
      hit_r   <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      hit_r   <= hit_nxt;
    end
  end

  // result queue
  assign in_ch.ready = (cnt_r != 2'd2);
  assign pop         = out_ch.valid && out_ch.ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  assign out_ch.valid       = (cnt_r != '0);
  assign out_ch.line_offset = q_r[rd_ptr_r].line_offset;
  assign out_ch.line_length = q_r[rd_ptr_r].line_length;
  assign out_ch.final_line  = q_r[rd_ptr_r].final_line;

endmodule

/* sv/fsl_checker.sv */
// ----------------------------------------------------------------------------
// fsl_checker
// Port-level checks of the line filter, bound to the top level.
// ----------------------------------------------------------------------------
module fsl_checker import fsl_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_kind,
  input logic [7:0] in_text_byte,
  input logic       out_valid,
  input logic       out_ready
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat present after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result queue");

  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready &&
                               (in_kind || (in_text_byte == NEWLINE_BYTE))))
    else $error("result beat without a closing input beat");

endmodule

bind fixed_string_line_filter_core fsl_checker u_fsl_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_kind      (in_ch.kind),
  .in_text_byte (in_ch.text_byte),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready)
);
